### hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int TAG_W         = 8;
  localparam int PRIO_W        = 16;
  localparam int TOTAL_W       = 5;
  localparam int STATUS_W      = 2;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic              req_type;
    logic [TAG_W-1:0]  item_name;
    logic [PRIO_W-1:0] item_priority;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    taken_name;
    logic [PRIO_W-1:0]   taken_priority;
    logic [TAG_W-1:0]    head_name;
    logic [PRIO_W-1:0]   head_priority;
    logic [TOTAL_W-1:0]  entry_total;
  } out_t;

  typedef struct packed {
    logic   insert;
    logic   remove;
    logic   override;
    entry_t item;
  } cell_ctrl_t;

endpackage

### hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t    prev_data,
  input  logic               prev_valid,
  input  logic               prev_at_after,
  input  spq_pkg::entry_t    next_data,
  input  logic               next_valid,
  output spq_pkg::entry_t    data,
  output logic               valid,
  output logic               at_after,
  output logic               tail_hit,
  output spq_pkg::entry_t    data_nxt,
  output logic               valid_nxt
);

  spq_pkg::entry_t data_r;
  logic            valid_r;
  logic            ge;

  assign ge       = valid_r & (data_r.prio >= ctrl.item.prio);
  assign at_after = ctrl.override ? ~valid_r : (ge | ~valid_r);
  assign tail_hit = valid_r & ~next_valid & (ctrl.item.prio >= data_r.prio);

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctrl.insert) begin
      if (at_after && !prev_at_after) begin
        data_nxt  = ctrl.item;
        valid_nxt = 1'b1;
      end else if (at_after) begin
        data_nxt  = prev_data;
        valid_nxt = prev_valid;
      end
    end else if (ctrl.remove) begin
      data_nxt  = next_data;
      valid_nxt = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data  = data_r;
  assign valid = valid_r;

endmodule

### hdl/spq_obuf.sv
// Two-entry result buffer: output register plus skid register.
module spq_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  spq_pkg::out_t push_data,
  input  logic          out_stall,
  output logic          out_valid,
  output spq_pkg::out_t out_data,
  output logic          skid_full
);

  logic          out_valid_r, out_valid_nxt;
  spq_pkg::out_t out_data_r, out_data_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  spq_pkg::out_t skid_data_r, skid_data_nxt;
  logic          take;

  assign take = out_valid_r & ~out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign skid_full = skid_valid_r;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a beat while the output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("beat pushed while the skid register is occupied");

  a_stalled_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result beat changed");

endmodule

### hdl/sorted_priority_queue_top.sv
// Sorted priority queue top level: chain of entry cells, fill counter and result buffer.
// The queue keeps up to DEPTH entries in a chain of cells ordered by ascending
// priority, with the head in the first cell. Every cell compares the broadcast
// priority of an enqueue with its own entry in the same cycle and either holds,
// takes the new entry or takes its neighbor's entry, so one enqueue or dequeue
// beat is accepted per clock cycle at any fill level unless the input stalls.
// Each result is registered in the output register, or the skid register if stalled.
// A two-entry result buffer keeps input beats flowing while one result waits; input
// stalls only when both result registers are occupied. The longest path is one 16-bit
// compare per cell followed by an OR across all cells to detect an append at the tail.
module sorted_priority_queue_top #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  spq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output spq_pkg::out_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                accept, is_full, is_empty, enq_ok, deq_ok, head_le;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     cell_data     [DEPTH];
  spq_pkg::entry_t     cell_data_nxt [DEPTH];
  logic [DEPTH-1:0]    cell_valid, cell_valid_nxt, cell_at_after, cell_tail_hit;
  spq_pkg::out_t       result;
  logic                skid_full;

  assign accept   = in_valid & ~in_stall;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign enq_ok   = accept & (in_data.req_type == spq_pkg::REQ_ENQ) & ~is_full;
  assign deq_ok   = accept & (in_data.req_type == spq_pkg::REQ_DEQ) & ~is_empty;
  assign head_le  = ~cell_valid[0] | (in_data.item_priority <= cell_data[0].prio);

  always_comb begin
    ctrl.insert    = enq_ok;
    ctrl.remove    = deq_ok;
    ctrl.override  = (|cell_tail_hit) & ~head_le;
    ctrl.item.tag  = in_data.item_name;
    ctrl.item.prio = in_data.item_priority;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t prev_data, next_data;
    logic            prev_valid, prev_at_after, next_valid;

    if (i == 0) begin : g_first
      assign prev_data     = ctrl.item;
      assign prev_valid    = 1'b1;
      assign prev_at_after = 1'b0;
    end else begin : g_mid
      assign prev_data     = cell_data[i-1];
      assign prev_valid    = cell_valid[i-1];
      assign prev_at_after = cell_at_after[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data  = cell_data[i];
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_data  = cell_data[i+1];
      assign next_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (ctrl),
      .prev_data     (prev_data),
      .prev_valid    (prev_valid),
      .prev_at_after (prev_at_after),
      .next_data     (next_data),
      .next_valid    (next_valid),
      .data          (cell_data[i]),
      .valid         (cell_valid[i]),
      .at_after      (cell_at_after[i]),
      .tail_hit      (cell_tail_hit[i]),
      .data_nxt      (cell_data_nxt[i]),
      .valid_nxt     (cell_valid_nxt[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (enq_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (deq_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    result.status         = spq_pkg::ST_DONE;
    result.taken_name     = '0;
    result.taken_priority = '0;
    if (in_data.req_type == spq_pkg::REQ_ENQ) begin
      if (is_full) begin
        result.status = spq_pkg::ST_FULL;
      end
    end else begin
      if (is_empty) begin
        result.status = spq_pkg::ST_EMPTY;
      end else begin
        result.taken_name     = cell_data[0].tag;
        result.taken_priority = cell_data[0].prio;
      end
    end
    result.head_name     = cell_valid_nxt[0] ? cell_data_nxt[0].tag : '0;
    result.head_priority = cell_valid_nxt[0] ? cell_data_nxt[0].prio : '0;
    result.entry_total   = spq_pkg::TOTAL_W'(count_nxt);
  end

  spq_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .skid_full (skid_full)
  );

  assign in_stall = skid_full;

  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("fill count disagrees with the occupied cells");

  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("occupied cells are not packed toward the head");

  for (genvar k = 1; k < DEPTH; k++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      cell_valid[k] |-> (cell_data[k-1].prio <= cell_data[k].prio))
      else $error("cell priorities out of order");
  end

endmodule

### tb/sorted_priority_queue_top_tb.sv
// Self-checking testbench for the sorted priority queue, checked against a shadow queue.
`timescale 1ns / 100ps

module sorted_priority_queue_top_tb;

  localparam int DEPTH      = spq_pkg::DEPTH_DEFAULT;
  localparam int TAG_W      = spq_pkg::TAG_W;
  localparam int PRIO_W     = spq_pkg::PRIO_W;
  localparam int TOTAL_W    = spq_pkg::TOTAL_W;
  localparam int RAND_ITEMS = 900;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 300;
  localparam int CYCLE_CAP  = 400000;
  localparam int PRINT_CAP  = 100;

  typedef struct {
    spq_pkg::in_t beat;
    bit           drain_first;
  } request_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  spq_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  spq_pkg::out_t out_data;

  request_t      request_q[$];
  spq_pkg::out_t due_outcomes[$];

  logic [PRIO_W-1:0] shadow_prio[DEPTH];
  logic [TAG_W-1:0]  shadow_tag[DEPTH];
  int                shadow_fill = 0;

  int unsigned beats_sent = 0;
  int unsigned beats_in = 0;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  sorted_priority_queue_top #(.DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic spq_pkg::out_t apply_request(spq_pkg::in_t b);
    spq_pkg::out_t r;
    int            pos;
    int            i;
    r = '0;
    r.status = spq_pkg::ST_DONE;
    if (b.req_type == spq_pkg::REQ_ENQ) begin
      if (shadow_fill >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        if (shadow_fill == 0 || b.item_priority <= shadow_prio[0]) begin
          pos = 0;
        end else if (b.item_priority >= shadow_prio[shadow_fill-1]) begin
          pos = shadow_fill;
        end else begin
          pos = shadow_fill;
          for (i = shadow_fill - 1; i >= 1; i--) begin
            if (shadow_prio[i] >= b.item_priority) pos = i;
          end
        end
        for (i = shadow_fill; i > pos; i--) begin
          shadow_prio[i] = shadow_prio[i-1];
          shadow_tag[i]  = shadow_tag[i-1];
        end
        shadow_prio[pos] = b.item_priority;
        shadow_tag[pos]  = b.item_name;
        shadow_fill++;
      end
    end else if (shadow_fill == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.taken_name     = shadow_tag[0];
      r.taken_priority = shadow_prio[0];
      for (i = 1; i < shadow_fill; i++) begin
        shadow_prio[i-1] = shadow_prio[i];
        shadow_tag[i-1]  = shadow_tag[i];
      end
      shadow_fill--;
    end
    if (shadow_fill > 0) begin
      r.head_name     = shadow_tag[0];
      r.head_priority = shadow_prio[0];
    end
    r.entry_total = TOTAL_W'(shadow_fill);
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PRIO_W-1:0] pick_prio();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return PRIO_W'($urandom_range(0, 16'hFFFF));
    if (r < 85) return PRIO_W'(16'h0100 + $urandom_range(0, 7));
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  task automatic add_request(logic req, logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio,
                             bit drain);
    request_t q;
    q.beat.req_type      = req;
    q.beat.item_name     = tag;
    q.beat.item_priority = prio;
    q.drain_first        = drain;
    request_q.push_back(q);
  endtask

  task automatic flag_mismatch(string field, logic [PRIO_W-1:0] got,
                               logic [PRIO_W-1:0] want);
    if (mismatches < PRINT_CAP) begin
      $display("%0t: result %0s got %h want %h", $realtime, field, got, want);
    end
    mismatches++;
  endtask

  function automatic bit calm_phase();
    return ((beats_in / 64) % 4) == 1;
  endfunction

  // Request driver: holds each beat until taken, then idles for a random gap.
  always @(negedge clk) begin
    logic         nv;
    spq_pkg::in_t nd;
    nv = in_valid;
    nd = in_data;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_valid || beats_in == beats_sent) begin
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (request_q.size() != 0 &&
                   !(request_q[0].drain_first && due_outcomes.size() != 0)) begin
        nd = request_q[0].beat;
        request_q.pop_front();
        nv = 1'b1;
        beats_sent++;
        in_gap = calm_phase() ? 0 : idle_len();
      end
    end
    in_valid <= nv;
    in_data  <= nd;
  end

  // Result stall: random bursts plus one long hold-off that backs the queue up.
  always @(negedge clk) begin
    logic ns;
    int unsigned len;
    ns = 1'b0;
    if (rst_n) begin
      if (!hold_done && beats_in >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        ns = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        ns = 1'b1;
        stall_left--;
      end else if (!calm_phase() && $urandom_range(0, 3) == 0) begin
        len = idle_len();
        if (len > 0) begin
          ns = 1'b1;
          stall_left = len - 1;
        end
      end
    end
    out_stall <= ns;
  end

  // Checks each result beat against the oldest prediction, then records accepted requests.
  always @(posedge clk) begin
    spq_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_outcomes.size() == 0) begin
        flag_mismatch("unexpected beat", PRIO_W'(out_data.status), '0);
      end else begin
        want = due_outcomes.pop_front();
        if (out_data.status !== want.status)
          flag_mismatch("status", PRIO_W'(out_data.status), PRIO_W'(want.status));
        if (out_data.taken_name !== want.taken_name)
          flag_mismatch("taken_name", PRIO_W'(out_data.taken_name), PRIO_W'(want.taken_name));
        if (out_data.taken_priority !== want.taken_priority)
          flag_mismatch("taken_priority", out_data.taken_priority, want.taken_priority);
        if (out_data.head_name !== want.head_name)
          flag_mismatch("head_name", PRIO_W'(out_data.head_name), PRIO_W'(want.head_name));
        if (out_data.head_priority !== want.head_priority)
          flag_mismatch("head_priority", out_data.head_priority, want.head_priority);
        if (out_data.entry_total !== want.entry_total)
          flag_mismatch("entry_total", PRIO_W'(out_data.entry_total),
                        PRIO_W'(want.entry_total));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      due_outcomes.push_back(apply_request(in_data));
      beats_in++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned seg;
    int unsigned mode;
    int unsigned r;
    logic        deq;

    // Empty dequeue, ties at head, tail and middle, extremes, then overflow and a few removals.
    add_request(spq_pkg::REQ_DEQ, 8'h00, 16'h0000, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'h00, 16'h8000, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'hFF, 16'h8000, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'h01, 16'hFFFF, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'h02, 16'hFFFF, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'h03, 16'h0000, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'h04, 16'h0000, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'h05, 16'h8000, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'h06, 16'h4000, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'h07, 16'hC000, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'hAA, 16'h5555, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'h55, 16'hAAAA, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'h0F, 16'h0001, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'hF0, 16'hFFFE, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'h3C, 16'h7FFF, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'hC3, 16'h8001, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'h5A, 16'h1234, 1'b0);
    add_request(spq_pkg::REQ_ENQ, 8'h99, 16'h0000, 1'b0);
    add_request(spq_pkg::REQ_DEQ, 8'hFF, 16'hFFFF, 1'b0);
    add_request(spq_pkg::REQ_DEQ, 8'h00, 16'h0000, 1'b0);
    add_request(spq_pkg::REQ_DEQ, 8'hFF, 16'hFFFF, 1'b0);
    add_request(spq_pkg::REQ_DEQ, 8'h00, 16'h0000, 1'b0);

    // Segments lean toward filling or draining, or stay balanced, so both full and empty are hit often.
    n = 0;
    while (n < RAND_ITEMS) begin
      seg  = $urandom_range(10, 60);
      mode = $urandom_range(0, 2);
      for (k = 0; k < seg && n < RAND_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0: deq = (r >= 80);
          1: deq = (r < 80);
          default: deq = (r < 50);
        endcase
        add_request(deq ? spq_pkg::REQ_DEQ : spq_pkg::REQ_ENQ,
                    TAG_W'($urandom_range(0, 255)), pick_prio(),
                    n == 0 || n == RAND_ITEMS / 2);
        n++;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || beats_in != beats_sent) @(posedge clk);
    while (due_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
